/* rtl/htd_pkg.sv */
// Shared types and constants for the tree-walk bit decoder.
// No dependencies; every other file depends on this package.
package htd_pkg;

	localparam int IDX_W  = 9;
	localparam int SYM_W  = 8;
	localparam int KIND_W = 2;
	localparam int BYTE_W = 8;
	localparam int BITS_W = $clog2(BYTE_W + 1);

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// kind 3 is legal and walks like an internal node
	localparam logic [KIND_W-1:0] KIND_INT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LEAF = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EOS  = 2'd2;

	typedef struct packed {
		logic [SYM_W-1:0]  symbol;
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  right;
		logic [IDX_W-1:0]  left;
	} node_t;

	typedef struct packed {
		logic              op;
		logic [IDX_W-1:0]  node_index;
		logic [IDX_W-1:0]  left_index;
		logic [IDX_W-1:0]  right_index;
		logic [KIND_W-1:0] node_kind;
		logic [SYM_W-1:0]  leaf_symbol;
		logic [BYTE_W-1:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] out_symbol;
		logic             last_of_byte;
	} out_item_t;

endpackage

/* rtl/htd_if.sv */
// Valid/ready channel interfaces for the decoder's input and result items.
// Depends on htd_pkg for the payload types.
interface htd_in_if;
	logic              valid;
	logic              ready;
	htd_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface htd_out_if;
	logic               valid;
	logic               ready;
	htd_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/huffman_tree_bit_decoder_top.sv */
// Tree-walk bit decoder top level: control sequencer, bit shifter, output stage.
// Depends on htd_pkg, htd_if.sv and htd_node_mem.
//
// Usage:
//   in_ch  (valid/ready) takes items. op = load writes one node entry
//          {left, right, kind, symbol} at node_index and restarts the walk at
//          the root; op = decode brings one body byte, walked MSB first.
//   out_ch (valid/ready) returns decoded symbols; last_of_byte marks the last
//          symbol a body byte produced. A byte may produce none.
//   cfg_we/cfg_wdata write the root index; the walk also moves to it.
// Timing:
//   A load is taken in S_IDLE and leaves the block idle. A decode item runs
//   accept, one root/current fetch, eight bit steps and one flush, one bit
//   per cycle while the output does not stall, paced by the node table read
//   feeding the next child address; it ends early once the stream has ended.
// Reset clears root and current node to 0, clears the end-of-stream flag
// and empties the output; table contents are undefined until loaded.
// A stalled receiver holds one symbol in the output register and one pending;
// the walk pauses when a third symbol is found and resumes once it drains.
module huffman_tree_bit_decoder_top #(
	parameter int NODE_COUNT = 512
) (
	input  logic                      clk,
	input  logic                      arst_n,
	htd_in_if.sink                    in_ch,
	htd_out_if.source                 out_ch,
	input  logic                      cfg_we,
	input  logic [htd_pkg::IDX_W-1:0] cfg_wdata
);
	import htd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIRST,
		S_STEP,
		S_FLUSH
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   root_q;
	logic [IDX_W-1:0]   cur_q;
	logic               ended_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [BITS_W-1:0]  bits_left_q;
	logic               pend_valid_q;
	logic [SYM_W-1:0]   pend_sym_q;
	logic               out_valid_q;
	logic [SYM_W-1:0]   out_sym_q;
	logic               out_last_q;

	logic               in_acc;
	logic               out_free;
	logic               mem_we;
	node_t              mem_wdata;
	logic               rd_en;
	logic [IDX_W-1:0]   raddr;
	node_t              node_e;
	node_t              root_e;
	node_t              walk_e;
	logic [IDX_W-1:0]   child;
	logic               is_eos;
	logic               is_leaf;
	logic               have_bits;
	logic               step_stall;

	htd_node_mem #(
		.NODE_COUNT(NODE_COUNT)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (in_ch.payload.node_index),
		.wdata   (mem_wdata),
		.re_a    (rd_en),
		.raddr_a (raddr),
		.rdata_a (node_e),
		.raddr_b (root_q),
		.rdata_b (root_e)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign mem_we           = in_acc && (in_ch.payload.op == OP_LOAD);
	assign mem_wdata.symbol = in_ch.payload.leaf_symbol;
	assign mem_wdata.kind   = in_ch.payload.node_kind;
	assign mem_wdata.right  = in_ch.payload.right_index;
	assign mem_wdata.left   = in_ch.payload.left_index;

	// node_e holds the entry of cur_q; in a step it is the node just reached
	assign is_eos     = (node_e.kind == KIND_EOS);
	assign is_leaf    = (node_e.kind == KIND_LEAF);
	assign have_bits  = (bits_left_q != '0);
	assign step_stall = is_leaf && pend_valid_q && !out_free;

	// after a leaf the next bit walks from the root
	assign walk_e = (state_q == S_STEP && is_leaf) ? root_e : node_e;
	assign child  = byte_q[BYTE_W-1] ? walk_e.right : walk_e.left;

	always_comb begin
		raddr = child;
		rd_en = 1'b0;
		case (state_q)
			S_IDLE: begin
				raddr = cur_q;
				rd_en = in_acc;
			end
			S_FIRST: begin
				rd_en = 1'b1;
			end
			S_STEP: begin
				rd_en = !is_eos && !step_stall && have_bits;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			root_q       <= '0;
			cur_q        <= '0;
			ended_q      <= 1'b0;
			byte_q       <= '0;
			bits_left_q  <= '0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
			out_valid_q  <= 1'b0;
			out_sym_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				root_q <= cfg_wdata;
				cur_q  <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_ch.payload.op == OP_LOAD) begin
							cur_q   <= root_q;
							ended_q <= 1'b0;
						end else begin
							byte_q      <= in_ch.payload.data_byte;
							bits_left_q <= BITS_W'(BYTE_W);
							state_q     <= S_FIRST;
						end
					end
				end
				S_FIRST: begin
					if (ended_q || root_e.kind == KIND_EOS) begin
						state_q <= S_IDLE;
					end else begin
						cur_q       <= child;
						byte_q      <= byte_q << 1;
						bits_left_q <= bits_left_q - BITS_W'(1);
						state_q     <= S_STEP;
					end
				end
				S_STEP: begin
					if (is_eos) begin
						ended_q <= 1'b1;
						state_q <= S_FLUSH;
					end else if (!step_stall) begin
						if (is_leaf) begin
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_sym_q   <= pend_sym_q;
								out_last_q  <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_sym_q   <= node_e.symbol;
						end
						if (have_bits) begin
							cur_q       <= child;
							byte_q      <= byte_q << 1;
							bits_left_q <= bits_left_q - BITS_W'(1);
						end else begin
							if (is_leaf) begin
								cur_q <= root_q;
							end
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_sym_q    <= pend_sym_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid                = out_valid_q;
	assign out_ch.payload.out_symbol   = out_sym_q;
	assign out_ch.payload.last_of_byte = out_last_q;

endmodule

/* rtl/htd_node_mem.sv */
// Node table: one write port, two registered read ports (walk and root).
// Indices at or beyond NODE_COUNT are dropped on write and read as zero.
module htd_node_mem #(
	parameter int NODE_COUNT = 512
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [htd_pkg::IDX_W-1:0]  waddr,
	input  htd_pkg::node_t             wdata,
	input  logic                       re_a,
	input  logic [htd_pkg::IDX_W-1:0]  raddr_a,
	output htd_pkg::node_t             rdata_a,
	input  logic [htd_pkg::IDX_W-1:0]  raddr_b,
	output htd_pkg::node_t             rdata_b
);
	import htd_pkg::*;

	localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

	node_t mem [NODE_COUNT];
	node_t rdata_a_q;
	node_t rdata_b_q;

	logic wr_ok, ra_ok, rb_ok;

	assign wr_ok = CMP_W'(waddr) < CMP_W'(NODE_COUNT);
	assign ra_ok = CMP_W'(raddr_a) < CMP_W'(NODE_COUNT);
	assign rb_ok = CMP_W'(raddr_b) < CMP_W'(NODE_COUNT);

	always_ff @(posedge clk) begin
		if (we && wr_ok) begin
			mem[ADDR_W'(waddr)] <= wdata;
		end
		if (re_a) begin
			rdata_a_q <= ra_ok ? mem[ADDR_W'(raddr_a)] : '0;
		end
		rdata_b_q <= rb_ok ? mem[ADDR_W'(raddr_b)] : '0;
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

/* test/tb_huffman_tree_bit_decoder_top.sv */
// Self-checking testbench for huffman_tree_bit_decoder_top: node loads, byte decodes, root writes.
// Depends on htd_pkg and the htd_in_if / htd_out_if interfaces; predicts symbols from its own
// copy of the node table and checks each result in order.
module tb_huffman_tree_bit_decoder_top;
	import htd_pkg::*;

	localparam int NODES         = 512;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 250;
	localparam int IN_W          = $bits(in_item_t);

	// kind three is stored as is and walks like an internal node
	localparam logic [KIND_W-1:0] KIND_ALT_INT = 2'd3;

	typedef enum logic [1:0] {ROW_LOAD, ROW_DECODE, ROW_ROOT} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [IDX_W-1:0]  idx;
		logic [IDX_W-1:0]  left;
		logic [IDX_W-1:0]  right;
		logic [KIND_W-1:0] nkind;
		logic [SYM_W-1:0]  sym;
		logic [BYTE_W-1:0] data;
		logic              typed;
		logic [3:0]        n_exp;
		logic [SYM_W-1:0]  exp_sym;
	} dir_row_t;

	// Tree: 0 -> {1: sym 00, 511 (kind three) -> {2: sym FF, 3: end of stream}}
	// codes: 0 = 00, 10 = FF, 11 = end of stream
	localparam dir_row_t DIRECTED [26] = '{
		'{ROW_LOAD,   9'd0,   9'd1,   9'd511, KIND_INT,     8'h5A, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_LOAD,   9'd1,   9'd0,   9'd0,   KIND_LEAF,    8'h00, 8'hFF, 1'b0, 4'd0, 8'h00},
		'{ROW_LOAD,   9'd511, 9'd2,   9'd3,   KIND_ALT_INT, 8'hA5, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_LOAD,   9'd2,   9'd511, 9'd511, KIND_LEAF,    8'hFF, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_LOAD,   9'd3,   9'd0,   9'd0,   KIND_EOS,     8'hC3, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h00, 1'b1, 4'd8, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'hAA, 1'b1, 4'd4, 8'hFF},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h80, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h7F, 1'b1, 4'd1, 8'h00},
		// stream has ended: nothing until a load
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h00, 1'b1, 4'd0, 8'h00},
		'{ROW_LOAD,   9'd4,   9'd511, 9'd511, KIND_LEAF,    8'h3C, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h52, 1'b0, 4'd0, 8'h00},
		'{ROW_ROOT,   9'd511, 9'd0,   9'd0,   KIND_INT,     8'h00, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h00, 1'b1, 4'd8, 8'hFF},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h80, 1'b1, 4'd0, 8'h00},
		// root is the end-of-stream leaf
		'{ROW_ROOT,   9'd3,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_LOAD,   9'd5,   9'd0,   9'd0,   KIND_LEAF,    8'h11, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'hFF, 1'b1, 4'd0, 8'h00},
		// root is a symbol leaf: walk steps through its children
		'{ROW_ROOT,   9'd2,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h55, 1'b0, 4'd0, 8'h00},
		// a root write does not clear the ended stream
		'{ROW_ROOT,   9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h9F, 1'b1, 4'd0, 8'h00},
		'{ROW_LOAD,   9'd5,   9'd0,   9'd0,   KIND_LEAF,    8'h11, 8'h00, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'h9F, 1'b0, 4'd0, 8'h00},
		'{ROW_DECODE, 9'd0,   9'd0,   9'd0,   KIND_INT,     8'h00, 8'hFF, 1'b0, 4'd0, 8'h00}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_wdata;

	htd_in_if  in_ch ();
	htd_out_if out_ch ();

	huffman_tree_bit_decoder_top #(
		.NODE_COUNT(NODES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor state
	node_t            node_tbl [NODES];
	bit               node_loaded [NODES];
	logic [IDX_W-1:0] root_sel;
	logic [IDX_W-1:0] walk_node;
	bit               stream_done;

	// Scratch results of one byte walk
	out_item_t        walk_out [$];
	logic [IDX_W-1:0] walk_next;
	bit               walk_next_done;

	out_item_t symbols_due [$];
	in_item_t  tree_loads [$];
	int        tree_root;

	int errors;
	int items_sent;
	int symbols_seen;
	bit hold_request;
	int hold_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Walks one byte from the current predictor state; results go to the scratch
	// variables. Returns 1 if the walk would touch an entry never loaded.
	function automatic bit walk_byte(input logic [BYTE_W-1:0] b);
		node_t            e;
		logic [IDX_W-1:0] nxt;
		out_item_t        r;
		bit               undef;

		walk_out.delete();
		walk_next      = walk_node;
		walk_next_done = stream_done;
		undef          = !node_loaded[root_sel];
		if (stream_done || node_tbl[root_sel].kind == KIND_EOS)
			return undef;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			undef |= !node_loaded[walk_next];
			e      = node_tbl[walk_next];
			nxt    = b[i] ? e.right : e.left;
			undef |= !node_loaded[nxt];
			walk_next = nxt;
			if (node_tbl[nxt].kind == KIND_EOS) begin
				walk_next_done = 1'b1;
				break;
			end
			if (node_tbl[nxt].kind == KIND_LEAF) begin
				r.out_symbol   = node_tbl[nxt].symbol;
				r.last_of_byte = 1'b0;
				walk_out = {walk_out, r};
				walk_next = root_sel;
			end
		end
		if (walk_out.size() > 0)
			walk_out[walk_out.size() - 1].last_of_byte = 1'b1;
		return undef;
	endfunction

	function automatic in_item_t make_load(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] l,
			input logic [IDX_W-1:0] r, input logic [KIND_W-1:0] k, input logic [SYM_W-1:0] s);
		in_item_t it;

		it.op          = OP_LOAD;
		it.node_index  = idx;
		it.left_index  = l;
		it.right_index = r;
		it.node_kind   = k;
		it.leaf_symbol = s;
		it.data_byte   = BYTE_W'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_decode(input logic [BYTE_W-1:0] b);
		in_item_t it;

		it           = in_item_t'(IN_W'({$urandom, $urandom}));
		it.op        = OP_DECODE;
		it.data_byte = b;
		return it;
	endfunction

	// Offers one item, waits for it to be taken and updates the predictor.
	// A typed item queues the given symbols in place of the predicted ones.
	task automatic send_item(input in_item_t it, input bit typed = 1'b0,
			input int n_exp = 0, input logic [SYM_W-1:0] exp_sym = '0);
		node_t     n;
		out_item_t r;

		@(negedge clk);
		while (!(items_sent >= 120 && items_sent < 170) && $urandom_range(0, 99) < 18) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= it;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		if (it.op == OP_LOAD) begin
			n.left                  = it.left_index;
			n.right                 = it.right_index;
			n.kind                  = it.node_kind;
			n.symbol                = it.leaf_symbol;
			node_tbl[it.node_index]    = n;
			node_loaded[it.node_index] = 1'b1;
			walk_node   = root_sel;
			stream_done = 1'b0;
		end else begin
			void'(walk_byte(it.data_byte));
			walk_node   = walk_next;
			stream_done = walk_next_done;
			if (!typed) begin
				foreach (walk_out[i])
					symbols_due = {symbols_due, walk_out[i]};
			end
		end
		if (typed) begin
			for (int i = 0; i < n_exp; i++) begin
				r.out_symbol   = exp_sym;
				r.last_of_byte = (i == n_exp - 1);
				symbols_due = {symbols_due, r};
			end
		end
	endtask

	// Drains the block, then writes a new root
	task automatic set_root(input logic [IDX_W-1:0] v);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (symbols_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		root_sel  = v;
		walk_node = v;
	endtask

	// Random full binary tree at random table slots, load order shuffled
	task automatic build_tree(input int n_leaves, input bit with_eos);
		int       open_nodes [$];
		bit       in_tree [NODES];
		int       a;
		int       b;
		int       p;
		int       idx;
		int       j;
		in_item_t tmp;

		tree_loads.delete();
		for (int i = 0; i < n_leaves; i++) begin
			do idx = $urandom_range(0, NODES - 1); while (in_tree[idx]);
			in_tree[idx] = 1'b1;
			tree_loads = {tree_loads, make_load(IDX_W'(idx), IDX_W'($urandom), IDX_W'($urandom),
				(with_eos && i == 0) ? KIND_EOS : KIND_LEAF, SYM_W'($urandom))};
			open_nodes = {open_nodes, idx};
		end
		while (open_nodes.size() > 1) begin
			p = $urandom_range(0, open_nodes.size() - 1);
			a = open_nodes[p];
			open_nodes.delete(p);
			p = $urandom_range(0, open_nodes.size() - 1);
			b = open_nodes[p];
			open_nodes.delete(p);
			do idx = $urandom_range(0, NODES - 1); while (in_tree[idx]);
			in_tree[idx] = 1'b1;
			tree_loads = {tree_loads, make_load(IDX_W'(idx), IDX_W'(a), IDX_W'(b),
				($urandom_range(0, 3) == 0) ? KIND_ALT_INT : KIND_INT, SYM_W'($urandom))};
			open_nodes = {open_nodes, idx};
		end
		tree_root = open_nodes[0];
		for (int i = tree_loads.size() - 1; i > 0; i--) begin
			j             = $urandom_range(0, i);
			tmp           = tree_loads[i];
			tree_loads[i] = tree_loads[j];
			tree_loads[j] = tmp;
		end
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= (symbols_seen >= 150 && symbols_seen < 230) ||
					$urandom_range(0, 99) >= 18;
			end
		end
	end

	always @(posedge clk) begin : check_symbols
		out_item_t want;

		if (arst_n && out_ch.valid && out_ch.ready) begin
			symbols_seen++;
			if (symbols_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected symbol, expected none, got %02h last %b", $time,
					out_ch.payload.out_symbol, out_ch.payload.last_of_byte);
			end else begin
				want = symbols_due.pop_front();
				if (out_ch.payload.out_symbol !== want.out_symbol) begin
					errors++;
					$display("%0t: out_symbol mismatch, expected %02h, got %02h", $time,
						want.out_symbol, out_ch.payload.out_symbol);
				end
				if (out_ch.payload.last_of_byte !== want.last_of_byte) begin
					errors++;
					$display("%0t: last_of_byte mismatch, expected %b, got %b", $time,
						want.last_of_byte, out_ch.payload.last_of_byte);
				end
			end
		end
	end

	initial begin
		int       target;
		int       phase;
		int       next_load;
		int       decodes;
		int       dec_target;
		int       r;
		bit       hold_done;
		logic [BYTE_W-1:0] b;
		dir_row_t row;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		errors        = 0;
		items_sent    = 0;
		symbols_seen  = 0;
		hold_request  = 1'b0;
		hold_done     = 1'b0;
		root_sel      = '0;
		walk_node     = '0;
		stream_done   = 1'b0;
		foreach (node_tbl[i]) begin
			node_tbl[i]    = '0;
			node_loaded[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < $size(DIRECTED); i++) begin
			row = DIRECTED[i];
			case (row.kind)
				ROW_ROOT: set_root(row.idx);
				ROW_LOAD: send_item(make_load(row.idx, row.left, row.right, row.nkind, row.sym));
				default: send_item(make_decode(row.data), row.typed, row.n_exp, row.exp_sym);
			endcase
		end

		target = items_sent + RANDOM_ITEMS;
		phase  = 0;
		while (items_sent < target) begin
			build_tree(($urandom_range(0, 7) == 0) ? 24 : $urandom_range(2, 8),
				(phase < 2 || hold_done) && $urandom_range(0, 2) == 0);
			set_root(IDX_W'(tree_root));
			next_load  = 0;
			decodes    = 0;
			dec_target = $urandom_range(6, 16);
			while (next_load < tree_loads.size() || decodes < dec_target) begin
				// keep the receiver off while items keep coming
				if (phase >= 2 && next_load == tree_loads.size() && !hold_done) begin
					hold_request = 1'b1;
					hold_done    = 1'b1;
				end
				r = $urandom_range(0, 99);
				if (r < 6) begin
					send_item(make_load(IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
						KIND_W'($urandom), SYM_W'($urandom)));
				end else if (stream_done && next_load > 0 && r < 40) begin
					send_item(tree_loads[$urandom_range(0, next_load - 1)]);
				end else if (next_load < tree_loads.size() && (r < 60 || decodes >= dec_target)) begin
					send_item(tree_loads[next_load]);
					next_load++;
				end else begin
					b = BYTE_W'($urandom);
					if (!walk_byte(b)) begin
						send_item(make_decode(b));
						decodes++;
					end else if (next_load < tree_loads.size()) begin
						send_item(tree_loads[next_load]);
						next_load++;
					end else begin
						break;
					end
				end
			end
			phase++;
		end

		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (symbols_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
